@@ src/wdt_pkg.sv @@
package wdt_pkg;

   localparam int ModeWidth  = 2;
   localparam int IndexWidth = 3;
   localparam int DataWidth  = 16;
   localparam int CountWidth = 32;
   localparam int LenWidth   = 8;
   localparam int PulseWidth = 9;

   // item kinds
   localparam logic [ModeWidth-1:0] MODE_TICK  = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_WRITE = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_READ  = 2'd2;

   // word register map
   localparam logic [IndexWidth-1:0] REG_CLEAR   = 3'd0;
   localparam logic [IndexWidth-1:0] REG_DUMMY   = 3'd1;
   localparam logic [IndexWidth-1:0] REG_CTRL    = 3'd2;
   localparam logic [IndexWidth-1:0] REG_IRQ_CMP = 3'd3;
   localparam logic [IndexWidth-1:0] REG_PER_LO  = 3'd4;
   localparam logic [IndexWidth-1:0] REG_PER_HI  = 3'd5;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 reset_out;
      logic                 irq_out;
   } result_type;

endpackage

@@ src/wdt_core.sv @@
module wdt_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic [wdt_pkg::ModeWidth-1:0]     mode,
   input  logic [wdt_pkg::IndexWidth-1:0]    reg_index,
   input  logic [wdt_pkg::DataWidth-1:0]     write_data,
   output wdt_pkg::result_type               result
);
   import wdt_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [DataWidth-1:0]  per_lo_ff, per_lo_in;
   logic [DataWidth-1:0]  per_hi_ff, per_hi_in;
   logic [DataWidth-1:0]  cmp_ff, cmp_in;
   logic [LenWidth-1:0]   len_ff, len_in;
   logic                  flag_ff, flag_in;
   logic [PulseWidth-1:0] pulse_ff, pulse_in;

   logic [CountWidth-1:0] period;
   logic [CountWidth-1:0] count_inc;

   assign period    = {per_hi_ff, per_lo_ff};
   assign count_inc = count_ff + CountWidth'(1);

   always_comb begin
      count_in  = count_ff;
      per_lo_in = per_lo_ff;
      per_hi_in = per_hi_ff;
      cmp_in    = cmp_ff;
      len_in    = len_ff;
      flag_in   = flag_ff;
      pulse_in  = pulse_ff;
      result    = '0;
      case (mode)
         MODE_TICK: begin
            if (pulse_ff != '0) begin
               result.reset_out = 1'b1;
               pulse_in = pulse_ff - PulseWidth'(1);
            end
            if (period != '0) begin
               count_in = count_inc;
               result.irq_out = (cmp_ff != '0) &&
                                (count_inc[CountWidth-1:DataWidth] == cmp_ff) &&
                                (count_inc[DataWidth-1:0] == '0);
               if (count_inc >= period) begin
                  count_in = '0;
                  flag_in  = 1'b1;
                  result.reset_out = 1'b1;
                  pulse_in = PulseWidth'(len_ff);
               end
            end
         end
         MODE_WRITE: begin
            case (reg_index)
               REG_CLEAR:   if (write_data[0]) count_in = '0;
               REG_CTRL: begin
                  len_in = write_data[DataWidth-1:DataWidth-LenWidth];
                  if (write_data[0]) flag_in = 1'b0;
               end
               REG_IRQ_CMP: cmp_in    = write_data;
               REG_PER_LO:  per_lo_in = write_data;
               REG_PER_HI:  per_hi_in = write_data;
               default: ;
            endcase
         end
         MODE_READ: begin
            case (reg_index)
               REG_CTRL:    result.read_data = {len_ff, {(DataWidth-LenWidth-1){1'b0}}, flag_ff};
               REG_IRQ_CMP: result.read_data = cmp_ff;
               REG_PER_LO:  result.read_data = per_lo_ff;
               REG_PER_HI:  result.read_data = per_hi_ff;
               default:     result.read_data = '0;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         per_lo_ff <= '0;
         per_hi_ff <= '0;
         cmp_ff    <= '0;
         len_ff    <= '0;
         flag_ff   <= 1'b0;
         pulse_ff  <= '0;
      end else if (item_valid) begin
         count_ff  <= count_in;
         per_lo_ff <= per_lo_in;
         per_hi_ff <= per_hi_in;
         cmp_ff    <= cmp_in;
         len_ff    <= len_in;
         flag_ff   <= flag_in;
         pulse_ff  <= pulse_in;
      end
   end

endmodule

@@ src/watchdog_timer_with_registers.sv @@
// watchdog timer behind a bank of 16-bit word registers
// request channel: req_valid/req_ready with req_mode (tick, bus write, bus read),
//    req_reg_index (word index) and req_write_data
// response channel: rsp_valid/rsp_ready, exactly one response per request,
//    carrying rsp_read_data, rsp_reset_out and rsp_irq_out
// response path: output register, or skid register while the output one is held
// throughput: one request per cycle while req_ready is high; the state update
//    is a single pass of logic (32-bit increment, compare) into response register
// stalls: a two-entry output buffer (output register plus skid register) lets
//    one more request transfer while a response waits; req_ready falls only
//    when both entries hold untaken responses
// reset: synchronous, active high; counter, period, compare value, pulse
//    length, sticky flag and pending pulse all clear, output buffer empties
module watchdog_timer_with_registers (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wdt_pkg::ModeWidth-1:0]     req_mode,
   input  logic [wdt_pkg::IndexWidth-1:0]    req_reg_index,
   input  logic [wdt_pkg::DataWidth-1:0]     req_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wdt_pkg::DataWidth-1:0]     rsp_read_data,
   output logic                              rsp_reset_out,
   output logic                              rsp_irq_out
);
   import wdt_pkg::*;

   // request transfer and its freshly computed response
   logic       push;
   logic       pop;
   result_type result;

   // output register and skid register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   wdt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (push),
      .mode       (req_mode),
      .reg_index  (req_reg_index),
      .write_data (req_write_data),
      .result     (result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no request transfers while the skid is full
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      // payload carries no reset
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_reset_out = out_ff.reset_out;
   assign rsp_irq_out   = out_ff.irq_out;

   // skid entry only ever sits behind a full output register
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while output register is empty");

   // every request transfer leaves a response on offer next cycle
   assert property (@(posedge clock) disable iff (reset) push |=> rsp_valid)
      else $error("request transfer produced no response");

   // a stalled response with a full skid blocks further requests
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && skid_valid_ff && !rsp_ready) |=> !req_ready)
      else $error("request side open while both output entries are held");

   // tick results and read data never mix
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reset_out || rsp_irq_out)) |-> (rsp_read_data == '0))
      else $error("tick response carries read data");

endmodule

@@ bench/watchdog_response_checker.sv @@
module watchdog_response_checker
   import wdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [ModeWidth-1:0]  req_mode,
   input  logic [IndexWidth-1:0] req_reg_index,
   input  logic [DataWidth-1:0]  req_write_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [DataWidth-1:0]  rsp_read_data,
   input  logic                  rsp_reset_out,
   input  logic                  rsp_irq_out,
   output int unsigned           failures,
   output int unsigned           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // own copy of the watchdog state
   logic [CountWidth-1:0] count_q;
   logic [DataWidth-1:0]  period_lo;
   logic [DataWidth-1:0]  period_hi;
   logic [DataWidth-1:0]  irq_cmp;
   logic [LenWidth-1:0]   pulse_len;
   logic                  expired_flag;
   logic [PulseWidth-1:0] pulse_left;

   result_type expected_responses[$];
   int unsigned reported;

   function automatic result_type advance_watchdog(input logic [ModeWidth-1:0]  mode,
                                                   input logic [IndexWidth-1:0] idx,
                                                   input logic [DataWidth-1:0]  data);
      result_type            res;
      logic [CountWidth-1:0] period;
      res    = '0;
      period = {period_hi, period_lo};
      case (mode)
         MODE_TICK: begin
            // pending pulse first, then count, compare match, expiry last
            if (pulse_left != 0) begin
               res.reset_out = 1'b1;
               pulse_left    = pulse_left - 1'b1;
            end
            if (period != 0) begin
               count_q = count_q + 1'b1;
               if (irq_cmp != 0 && count_q[31:16] == irq_cmp && count_q[15:0] == 0)
                  res.irq_out = 1'b1;
               if (count_q >= period) begin
                  count_q       = '0;
                  expired_flag  = 1'b1;
                  res.reset_out = 1'b1;
                  pulse_left    = PulseWidth'(pulse_len);
               end
            end
         end
         MODE_WRITE: begin
            case (idx)
               REG_CLEAR:   if (data[0]) count_q = '0;
               REG_CTRL: begin
                  pulse_len = data[15:8];
                  if (data[0]) expired_flag = 1'b0;
               end
               REG_IRQ_CMP: irq_cmp   = data;
               REG_PER_LO:  period_lo = data;
               REG_PER_HI:  period_hi = data;
               default: ;
            endcase
         end
         MODE_READ: begin
            case (idx)
               REG_CTRL:    res.read_data = {pulse_len, 7'd0, expired_flag};
               REG_IRQ_CMP: res.read_data = irq_cmp;
               REG_PER_LO:  res.read_data = period_lo;
               REG_PER_HI:  res.read_data = period_hi;
               default:     res.read_data = '0;
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         count_q      = '0;
         period_lo    = '0;
         period_hi    = '0;
         irq_cmp      = '0;
         pulse_len    = '0;
         expired_flag = 1'b0;
         pulse_left   = '0;
         expected_responses.delete();
         failures     = 0;
         reported     = 0;
         outstanding <= 0;
      end else begin
         // response side before request side, so a response never answers a request taken in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: response with nothing outstanding: rd=%h rst=%b irq=%b",
                           $realtime, rsp_read_data, rsp_reset_out, rsp_irq_out);
               end
            end else begin
               want = expected_responses.pop_front();
               if (want.read_data !== rsp_read_data || want.reset_out !== rsp_reset_out ||
                   want.irq_out !== rsp_irq_out) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: mismatch: expected rd=%h rst=%b irq=%b, got rd=%h rst=%b irq=%b",
                              $realtime, want.read_data, want.reset_out, want.irq_out,
                              rsp_read_data, rsp_reset_out, rsp_irq_out);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_responses.push_back(advance_watchdog(req_mode, req_reg_index,
                                                          req_write_data));
         outstanding <= expected_responses.size();
      end
   end

endmodule

@@ bench/watchdog_timer_with_registers_test.sv @@
module watchdog_timer_with_registers_test;
   import wdt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // mode value the block leaves unused, and a register index nothing decodes
   localparam logic [ModeWidth-1:0]  MODE_UNUSED  = 2'd3;
   localparam logic [IndexWidth-1:0] REG_UNMAPPED = 3'd6;

   localparam int RandomBlocks  = 29;
   localparam int BlockItems    = 50;
   localparam int SettleCycles  = 5;
   localparam int CycleLimit    = 600000;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [ModeWidth-1:0]  req_mode       = MODE_TICK;
   logic [IndexWidth-1:0] req_reg_index  = REG_CLEAR;
   logic [DataWidth-1:0]  req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [DataWidth-1:0]  rsp_read_data;
   logic                  rsp_reset_out;
   logic                  rsp_irq_out;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   // when clear, both sides run flat out with no gaps or stalls
   bit          idle_on     = 1'b1;

   watchdog_timer_with_registers uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_reset_out  (rsp_reset_out),
      .rsp_irq_out    (rsp_irq_out)
   );

   watchdog_response_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_reset_out  (rsp_reset_out),
      .rsp_irq_out    (rsp_irq_out),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog on the run as a whole
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CycleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // one request transfer, after a random gap when idling is on;
   // valid stays high straight into the next item when there is no gap
   task automatic send_item(input logic [ModeWidth-1:0]  mode,
                            input logic [IndexWidth-1:0] idx,
                            input logic [DataWidth-1:0]  data);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_reg_index  <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IndexWidth-1:0] idx,
                            input logic [DataWidth-1:0]  data);
      send_item(MODE_WRITE, idx, data);
   endtask

   task automatic tick_n(input int unsigned n);
      repeat (n) send_item(MODE_TICK, REG_CLEAR, '0);
   endtask

   // sender holds off until every outstanding response has come back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // response side: a random stall before each transfer when idling is on
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [ModeWidth-1:0]  mode;
      logic [IndexWidth-1:0] idx;
      logic [DataWidth-1:0]  data;
      logic [LenWidth-1:0]   len;
      int unsigned           pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // every register straight out of reset, unmapped ones included
      for (int r = 0; r < 8; r++) send_item(MODE_READ, IndexWidth'(r), '0);
      // period zero: counter holds, nothing fires
      tick_n(1);
      // all-ones into compare, period and dummy registers, top byte into control, then read some back
      write_reg(REG_CTRL, 16'hFF01);
      write_reg(REG_IRQ_CMP, 16'hFFFF);
      write_reg(REG_PER_LO, 16'hFFFF);
      write_reg(REG_PER_HI, 16'hFFFF);
      write_reg(REG_DUMMY, 16'hFFFF);
      send_item(MODE_READ, REG_CTRL, '0);
      send_item(MODE_READ, REG_PER_HI, '0);
      // unused mode with every bit set: no effect, all-zero response
      send_item(MODE_UNUSED, 3'h7, 16'hFFFF);
      // short period and a two-tick pulse: expiry, then pulse tail
      write_reg(REG_CTRL, 16'h0100);
      write_reg(REG_PER_HI, 16'h0000);
      write_reg(REG_PER_LO, 16'h0002);
      write_reg(REG_IRQ_CMP, 16'h0000);
      tick_n(4);
      // clear with bit 0 low does nothing, with bit 0 high restarts
      write_reg(REG_CLEAR, 16'hFFFE);
      write_reg(REG_CLEAR, 16'h0001);

      // --- random part ---
      // ticks dominate so the counter keeps reaching short periods;
      // period writes lowered mid-count give the count-above-period expiry
      for (int blk = 0; blk < RandomBlocks; blk++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < BlockItems; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      mode = MODE_TICK;
            else if (pick < 75) mode = MODE_WRITE;
            else if (pick < 95) mode = MODE_READ;
            else                mode = MODE_UNUSED;
            idx  = IndexWidth'($urandom_range(0, 7));
            data = DataWidth'($urandom_range(0, 16'hFFFF));
            if (mode == MODE_WRITE) begin
               case (idx)
                  REG_PER_HI:
                     if ($urandom_range(0, 7) != 0) data = '0;
                  REG_PER_LO: begin
                     pick = $urandom_range(0, 9);
                     if (pick == 0)      data = '0;
                     else if (pick != 1) data = DataWidth'($urandom_range(1, 40));
                  end
                  REG_CTRL: begin
                     // long pulses now and then, mostly short ones
                     len = ($urandom_range(0, 7) == 0) ? LenWidth'($urandom_range(0, 255))
                                                       : LenWidth'($urandom_range(0, 6));
                     data = {len, data[7:0]};
                  end
                  REG_IRQ_CMP:
                     if ($urandom_range(0, 1) != 0) data = DataWidth'($urandom_range(0, 1));
                  default: ;
               endcase
            end else if (mode == MODE_READ && $urandom_range(0, 9) == 0) begin
               idx = REG_UNMAPPED;
            end
            send_item(mode, idx, data);
         end
         if (blk == 0 || $urandom_range(0, 3) == 0) wait_for_responses();
      end

      // --- wind-down ---
      wait_for_responses();
      repeat (SettleCycles) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
